// File: rtl/core/idl_pkg.sv
// ----------------------------------------------------------------------------
// idl_pkg
// shared types and constants for the indexed deque list
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OP_W     = 4;
    localparam int IDX_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_FRONT      = 4'd4,
        OP_BACK       = 4'd5,
        OP_AT         = 4'd6,
        OP_INSERT     = 4'd7,
        OP_REMOVE     = 4'd8,
        OP_CLEAR      = 4'd9
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_GET,
        S_GOT,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP
    } t_state;

endpackage

// File: rtl/core/indexed_deque_list_top.sv
// ----------------------------------------------------------------------------
// indexed_deque_list_top
// sequence: push/insert shift entries up (S_INS_RD, S_INS_WR), then write;
//   pop/remove read (S_GET, S_GOT), then shift down (S_DEL_RD, S_DEL_WR);
//   front/back/at read (S_GET, S_GOT); rejected, clear and unused go to S_RESP
// throughput: one request at a time; a shift moves one entry per read/write pair
// reset: synchronous active low, list empty, entries undefined until written
// ----------------------------------------------------------------------------
module indexed_deque_list_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [idl_pkg::OP_W-1:0]            i_op,
    input  logic [idl_pkg::IDX_W-1:0]           i_index,
    input  logic signed [idl_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [idl_pkg::DATA_W-1:0]   o_data_out,
    output logic [idl_pkg::STAT_W-1:0]          o_status,
    output logic [idl_pkg::CNT_W-1:0]           o_count,
    output logic                                o_is_empty
);

    localparam int AW = idl_pkg::ADDR_W;
    localparam int CW = idl_pkg::CNT_W;
    localparam int DW = idl_pkg::DATA_W;

    idl_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_pos, n_pos;
    logic [DW-1:0]        r_val, n_val;
    logic [DW-1:0]        r_data, n_data;
    idl_pkg::t_status     r_stat, n_stat;
    logic                 r_remove, n_remove;

    logic                 r_out_valid, n_out_valid;
    logic [DW-1:0]        r_out_data, n_out_data;
    logic [idl_pkg::STAT_W-1:0] r_out_stat, n_out_stat;
    logic [CW-1:0]        r_out_cnt, n_out_cnt;
    logic                 r_out_empty, n_out_empty;

    // entry memory
    logic [DW-1:0]        mem [idl_pkg::CAPACITY];
    logic [DW-1:0]        r_rdata;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [DW-1:0]        wr_data;

    // shared pointer unit
    logic [AW-1:0]        ptr_dec, ptr_inc;
    logic                 ptr_above_pos;
    logic                 ptr_next_in_list;

    logic                 accept;
    logic                 resp_go;
    logic                 full, empty;
    logic [CW-1:0]        idx_ext;

    assign ptr_dec          = r_ptr - AW'(1);
    assign ptr_inc          = r_ptr + AW'(1);
    assign ptr_above_pos    = r_ptr > r_pos;
    assign ptr_next_in_list = (CW'(r_ptr) + CW'(1)) < r_cnt;

    assign accept  = i_in_valid && (r_state == idl_pkg::S_IDLE);
    assign resp_go = (r_state == idl_pkg::S_RESP) && (!r_out_valid || !i_out_stall);
    assign full    = r_cnt >= CW'(idl_pkg::CAPACITY);
    assign empty   = r_cnt == '0;
    assign idx_ext = CW'(i_index);

    assign o_in_stall  = r_state != idl_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_stat;
    assign o_count     = r_out_cnt;
    assign o_is_empty  = r_out_empty;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            idl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = idl_pkg::S_RESP;
                    case (idl_pkg::t_op'(i_op))
                        idl_pkg::OP_PUSH_BACK, idl_pkg::OP_PUSH_FRONT: begin
                            if (!full) n_state = idl_pkg::S_INS_RD;
                        end
                        idl_pkg::OP_POP_FRONT, idl_pkg::OP_POP_BACK,
                        idl_pkg::OP_FRONT, idl_pkg::OP_BACK: begin
                            if (!empty) n_state = idl_pkg::S_GET;
                        end
                        idl_pkg::OP_AT, idl_pkg::OP_REMOVE: begin
                            if (idx_ext < r_cnt) n_state = idl_pkg::S_GET;
                        end
                        idl_pkg::OP_INSERT: begin
                            if (idx_ext <= r_cnt && !full) n_state = idl_pkg::S_INS_RD;
                        end
                        default: n_state = idl_pkg::S_RESP;
                    endcase
                end
            end
            idl_pkg::S_INS_RD: begin
                n_state = ptr_above_pos ? idl_pkg::S_INS_WR : idl_pkg::S_RESP;
            end
            idl_pkg::S_INS_WR: n_state = idl_pkg::S_INS_RD;
            idl_pkg::S_GET:    n_state = idl_pkg::S_GOT;
            idl_pkg::S_GOT: begin
                n_state = r_remove ? idl_pkg::S_DEL_RD : idl_pkg::S_RESP;
            end
            idl_pkg::S_DEL_RD: begin
                n_state = ptr_next_in_list ? idl_pkg::S_DEL_WR : idl_pkg::S_RESP;
            end
            idl_pkg::S_DEL_WR: n_state = idl_pkg::S_DEL_RD;
            idl_pkg::S_RESP: begin
                if (resp_go) n_state = idl_pkg::S_IDLE;
            end
            default: n_state = idl_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_val       = r_val;
        n_data      = r_data;
        n_stat      = r_stat;
        n_remove    = r_remove;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        n_out_empty = r_out_empty;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        wr_addr     = r_ptr;
        rd_addr     = r_ptr;
        wr_data     = r_rdata;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        case (r_state)
            idl_pkg::S_IDLE: begin
                if (accept) begin
                    n_val    = i_value;
                    n_data   = '0;
                    n_stat   = idl_pkg::ST_OK;
                    n_remove = 1'b0;
                    n_ptr    = AW'(r_cnt);
                    n_pos    = '0;
                    case (idl_pkg::t_op'(i_op))
                        idl_pkg::OP_PUSH_BACK: begin
                            n_pos = AW'(r_cnt);
                            if (full) n_stat = idl_pkg::ST_FULL;
                        end
                        idl_pkg::OP_PUSH_FRONT: begin
                            if (full) n_stat = idl_pkg::ST_FULL;
                        end
                        idl_pkg::OP_POP_FRONT: begin
                            n_ptr    = '0;
                            n_remove = 1'b1;
                            if (empty) n_stat = idl_pkg::ST_RANGE;
                        end
                        idl_pkg::OP_POP_BACK: begin
                            n_ptr    = AW'(r_cnt - CW'(1));
                            n_remove = 1'b1;
                            if (empty) n_stat = idl_pkg::ST_RANGE;
                        end
                        idl_pkg::OP_FRONT: begin
                            n_ptr = '0;
                            if (empty) n_stat = idl_pkg::ST_RANGE;
                        end
                        idl_pkg::OP_BACK: begin
                            n_ptr = AW'(r_cnt - CW'(1));
                            if (empty) n_stat = idl_pkg::ST_RANGE;
                        end
                        idl_pkg::OP_AT: begin
                            n_ptr = AW'(i_index);
                            if (idx_ext >= r_cnt) n_stat = idl_pkg::ST_RANGE;
                        end
                        idl_pkg::OP_INSERT: begin
                            n_pos = AW'(i_index);
                            // range check ranks above the full check
                            if (idx_ext > r_cnt) n_stat = idl_pkg::ST_RANGE;
                            else if (full) n_stat = idl_pkg::ST_FULL;
                        end
                        idl_pkg::OP_REMOVE: begin
                            n_ptr    = AW'(i_index);
                            n_remove = 1'b1;
                            if (idx_ext >= r_cnt) n_stat = idl_pkg::ST_RANGE;
                        end
                        idl_pkg::OP_CLEAR: n_cnt = '0;
                        default: n_stat = idl_pkg::ST_OK;
                    endcase
                end
            end
            idl_pkg::S_INS_RD: begin
                if (ptr_above_pos) begin
                    mem_re  = 1'b1;
                    rd_addr = ptr_dec;
                end else begin
                    // gap is open, drop the new entry in
                    mem_we  = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_val;
                    n_cnt   = r_cnt + CW'(1);
                end
            end
            idl_pkg::S_INS_WR: begin
                mem_we  = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rdata;
                n_ptr   = ptr_dec;
            end
            idl_pkg::S_GET: begin
                mem_re  = 1'b1;
                rd_addr = r_ptr;
            end
            idl_pkg::S_GOT: n_data = r_rdata;
            idl_pkg::S_DEL_RD: begin
                if (ptr_next_in_list) begin
                    mem_re  = 1'b1;
                    rd_addr = ptr_inc;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            idl_pkg::S_DEL_WR: begin
                mem_we  = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rdata;
                n_ptr   = ptr_inc;
            end
            idl_pkg::S_RESP: begin
                if (resp_go) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data;
                    n_out_stat  = r_stat;
                    n_out_cnt   = r_cnt;
                    n_out_empty = r_cnt == '0;
                end
            end
            default: n_stat = r_stat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        if (mem_re) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idl_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_data      <= n_data;
        r_stat      <= n_stat;
        r_remove    <= n_remove;
        r_out_data  <= n_out_data;
        r_out_stat  <= n_out_stat;
        r_out_cnt   <= n_out_cnt;
        r_out_empty <= n_out_empty;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(idl_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("request accepted without entering the sequencer");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |->
            (r_cnt == $past(r_cnt) + CW'(1) || r_cnt == $past(r_cnt) - CW'(1) ||
             r_cnt == '0))
        else $error("count moved by more than one entry");

    a_ins_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == idl_pkg::S_INS_RD) |-> (r_ptr >= r_pos))
        else $error("insert shift pointer passed the target slot");

    a_resp_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !resp_go)
        else $error("result overwritten while stalled");

endmodule
